@@ rtl/grc_pkg.sv @@
// Shared types, codes and constants of the grid raycast column renderer.
// Holds the quarter-wave sine table, glyph codes and the controller/datapath
// interface. Depends on nothing.
package grc_pkg;

	// Map geometry is fixed: 16x16 tiles, four 64-bit configuration words.
	localparam int MAP_SIZE   = 16;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS_0_TO_3   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS_4_TO_7   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS_8_TO_11  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS_12_TO_15 = 2'd3;

	// Glyph codes.
	localparam logic [7:0] G_SPACE = 8'd32;
	localparam logic [7:0] G_FULL  = 8'd219;
	localparam logic [7:0] G_DARK  = 8'd178;
	localparam logic [7:0] G_MED   = 8'd177;
	localparam logic [7:0] G_LIGHT = 8'd176;
	localparam logic [7:0] G_HASH  = 8'd35;
	localparam logic [7:0] G_X     = 8'd120;
	localparam logic [7:0] G_DOT   = 8'd46;
	localparam logic [7:0] G_DASH  = 8'd45;

	// tan(0.007) in Q16.
	localparam logic [8:0] EDGE_TAN_Q16 = 9'd459;

	// Datapath operation codes.
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_TRIG = 4'd2;
	localparam logic [3:0] OP_INIT = 4'd3;
	localparam logic [3:0] OP_STEP = 4'd4;
	localparam logic [3:0] OP_VEC  = 4'd5;
	localparam logic [3:0] OP_SQ   = 4'd6;
	localparam logic [3:0] OP_D2   = 4'd7;
	localparam logic [3:0] OP_SEL  = 4'd8;
	localparam logic [3:0] OP_DOT  = 4'd9;
	localparam logic [3:0] OP_CRS  = 4'd10;
	localparam logic [3:0] OP_ABS  = 4'd11;
	localparam logic [3:0] OP_TAN  = 4'd12;
	localparam logic [3:0] OP_PREP = 4'd13;
	localparam logic [3:0] OP_EMIT = 4'd14;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] k;     // corner under work, {dx, dy}
	} cmd_t;

	typedef struct packed {
		logic step_out;    // the new test point left the map
		logic step_wall;   // the new test point sits in a wall tile
		logic step_last;   // the step just taken reaches the depth limit
		logic k_excl;      // corner k is the farthest one and is skipped
		logic edge_pass;   // corner k lies within the angular bound
		logic out_free;    // the output register can take a word
		logic last_y;      // the row counter is at the bottom row
	} status_t;

	// Quarter-wave sine, Q1.14, one entry per 16 phase units.
	localparam logic [14:0] QSIN [65] = '{
		15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,
		15'd2801,  15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,
		15'd5520,  15'd5897,  15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,
		15'd8076,  15'd8423,  15'd8765,  15'd9102,  15'd9434,  15'd9760,  15'd10080,
		15'd10394, 15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
		15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623, 15'd13842,
		15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978, 15'd15137,
		15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
		15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364,
		15'd16379, 15'd16384
	};

	// Sine of a 12-bit phase, interpolated, rounded half up, Q1.14.
	function automatic logic signed [15:0] sin_q14(input logic [11:0] ph);
		logic [1:0]  q;
		logic [10:0] r;
		logic [6:0]  i;
		logic [3:0]  f;
		logic [14:0] a;
		logic [14:0] b;
		logic [8:0]  diff;
		logic [13:0] t;
		logic [14:0] v;
		q = ph[11:10];
		r = q[0] ? (11'd1024 - {1'b0, ph[9:0]}) : {1'b0, ph[9:0]};
		i = r[10:4];
		f = r[3:0];
		if (i >= 7'd64) begin
			v = QSIN[64];
		end else begin
			a = QSIN[i];
			b = QSIN[i + 7'd1];
			diff = 9'(b - a);
			t = {5'b0, diff} * {10'b0, f} + 14'd8;
			v = a + 15'(t[13:4]);
		end
		return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

endpackage

@@ rtl/grc_ctrl.sv @@
// Controller of the column renderer: sequences trig setup, ray march,
// corner test and row emission. Depends on grc_pkg.
module grc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  grc_pkg::status_t st,
	output grc_pkg::cmd_t    cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TRIG = 4'd1;
	localparam logic [3:0] S_INIT = 4'd2;
	localparam logic [3:0] S_STEP = 4'd3;
	localparam logic [3:0] S_VEC  = 4'd4;
	localparam logic [3:0] S_SQ   = 4'd5;
	localparam logic [3:0] S_D2   = 4'd6;
	localparam logic [3:0] S_SEL  = 4'd7;
	localparam logic [3:0] S_CHK  = 4'd8;
	localparam logic [3:0] S_VEC2 = 4'd9;
	localparam logic [3:0] S_DOT  = 4'd10;
	localparam logic [3:0] S_CRS  = 4'd11;
	localparam logic [3:0] S_ABS  = 4'd12;
	localparam logic [3:0] S_TAN  = 4'd13;
	localparam logic [3:0] S_PREP = 4'd14;
	localparam logic [3:0] S_ROWS = 4'd15;

	logic [3:0] state_q, state_d;
	logic [1:0] k_q, k_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		k_d = k_q;
		cmd.op = grc_pkg::OP_NONE;
		cmd.k = k_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = grc_pkg::OP_LOAD;
					state_d = S_TRIG;
				end
			end
			S_TRIG: begin
				cmd.op = grc_pkg::OP_TRIG;
				state_d = S_INIT;
			end
			S_INIT: begin
				cmd.op = grc_pkg::OP_INIT;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.op = grc_pkg::OP_STEP;
				if (st.step_out) begin
					state_d = S_PREP;
				end else if (st.step_wall) begin
					k_d = 2'd0;
					state_d = S_VEC;
				end else if (st.step_last) begin
					state_d = S_PREP;
				end
			end
			S_VEC: begin
				cmd.op = grc_pkg::OP_VEC;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op = grc_pkg::OP_SQ;
				state_d = S_D2;
			end
			S_D2: begin
				cmd.op = grc_pkg::OP_D2;
				if (k_q == 2'd3) begin
					state_d = S_SEL;
				end else begin
					k_d = k_q + 2'd1;
					state_d = S_VEC;
				end
			end
			S_SEL: begin
				cmd.op = grc_pkg::OP_SEL;
				k_d = 2'd0;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (!st.k_excl) begin
					state_d = S_VEC2;
				end else if (k_q == 2'd3) begin
					state_d = S_PREP;
				end else begin
					k_d = k_q + 2'd1;
				end
			end
			S_VEC2: begin
				cmd.op = grc_pkg::OP_VEC;
				state_d = S_DOT;
			end
			S_DOT: begin
				cmd.op = grc_pkg::OP_DOT;
				state_d = S_CRS;
			end
			S_CRS: begin
				cmd.op = grc_pkg::OP_CRS;
				state_d = S_ABS;
			end
			S_ABS: begin
				cmd.op = grc_pkg::OP_ABS;
				state_d = S_TAN;
			end
			S_TAN: begin
				cmd.op = grc_pkg::OP_TAN;
				if (st.edge_pass || k_q == 2'd3) begin
					state_d = S_PREP;
				end else begin
					k_d = k_q + 2'd1;
					state_d = S_CHK;
				end
			end
			S_PREP: begin
				cmd.op = grc_pkg::OP_PREP;
				state_d = S_ROWS;
			end
			S_ROWS: begin
				if (st.out_free) begin
					cmd.op = grc_pkg::OP_EMIT;
					if (st.last_y) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= 2'd0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
		end
	end

endmodule

@@ rtl/grc_dp.sv @@
// Datapath of the column renderer: map registers, ray march accumulators,
// corner test multipliers and the output word register. Depends on grc_pkg.
module grc_dp #(
	parameter int SCREEN_WIDTH  = 120,
	parameter int SCREEN_HEIGHT = 40,
	parameter int MAX_DEPTH     = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grc_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [15:0]                    player_x,
	input  logic [15:0]                    player_y,
	input  logic [11:0]                    player_angle,
	input  logic [6:0]                     column,
	input  grc_pkg::cmd_t                  cmd,
	output grc_pkg::status_t               st,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [5:0]                     row,
	output logic [7:0]                     glyph,
	output logic [5:0]                     distance_steps,
	output logic                           edge_seen,
	output logic                           last_row
);

	localparam int MAXN = 2 * MAX_DEPTH;
	localparam int NW   = $clog2(MAXN + 1);
	localparam int NE   = 2 ** NW;
	localparam int C    = $clog2(MAXN);
	localparam int TW   = ((15 + C > 19) ? 15 + C : 19) + 2;
	localparam int YW   = $clog2(SCREEN_HEIGHT);
	localparam int CW   = $clog2(SCREEN_HEIGHT) + 3;

	localparam logic [NW-1:0] MAXN_V = NW'(MAXN);
	localparam logic [YW-1:0] YLAST  = YW'(SCREEN_HEIGHT - 1);
	localparam logic [9:0]    MD10   = 10'(MAX_DEPTH);
	localparam logic [15:0]   H1     = 16'(SCREEN_HEIGHT);
	localparam logic [15:0]   H3     = 16'(3 * SCREEN_HEIGHT);
	localparam logic [15:0]   H9     = 16'(9 * SCREEN_HEIGHT);

	// Column to phase offset and distance to ceiling tables, built at elaboration.
	logic [11:0]          col_off [128];
	logic signed [CW-1:0] ceil_tab [NE];

	for (genvar i = 0; i < 128; i++) begin : g_off
		localparam int OFF = (i * 512) / SCREEN_WIDTH;
		assign col_off[i] = 12'(OFF);
	end

	for (genvar j = 0; j < NE; j++) begin : g_ceil
		if (j == 0) begin : g_zero
			assign ceil_tab[j] = '0;
		end else begin : g_val
			localparam int CV = (SCREEN_HEIGHT * j - 4 * SCREEN_HEIGHT) / (2 * j);
			assign ceil_tab[j] = CW'(CV);
		end
	end

	logic [63:0]          map_q [4];
	logic [15:0]          px_q, py_q;
	logic [11:0]          ph_q;
	logic signed [15:0]   ex_q, ey_q;
	logic signed [TW-1:0] tx_q, ty_q;
	logic [NW-1:0]        n_q;
	logic [3:0]           cx_q, cy_q;
	logic signed [17:0]   vx_q, vy_q;
	logic signed [35:0]   prod0_q, prod1_q;
	logic [36:0]          d2_q [4];
	logic [1:0]           excl_q;
	logic signed [36:0]   dot_q;
	logic [35:0]          crs_q;
	logic                 edge_q;
	logic signed [CW-1:0] ceil_q, floor_q;
	logic [7:0]           shade_q;
	logic [YW-1:0]        y_q;
	logic                 out_valid_q;
	logic [5:0]           row_q;
	logic [7:0]           glyph_q;
	logic [5:0]           dist_q;
	logic                 edge_out_q;
	logic                 last_q;

	// March step.
	logic signed [TW-1:0] tx_nx, ty_nx;
	logic                 nx_out;
	logic [3:0]           tcx, tcy;
	logic [63:0]          wword;
	logic                 nx_wall;

	assign tx_nx = tx_q + TW'(ex_q);
	assign ty_nx = ty_q + TW'(ey_q);
	assign nx_out = tx_nx[TW-1] || ty_nx[TW-1] || (|tx_nx[TW-2:19]) || (|ty_nx[TW-2:19]);
	assign tcx = tx_nx[18:15];
	assign tcy = ty_nx[18:15];
	assign wword = map_q[tcy[3:2]];
	assign nx_wall = wword[{tcy[1:0], tcx}];

	// Corner vector of corner k.
	logic [4:0]         ccx, ccy;
	logic signed [17:0] vx_c, vy_c;

	assign ccx = {1'b0, cx_q} + {4'b0, cmd.k[1]};
	assign ccy = {1'b0, cy_q} + {4'b0, cmd.k[0]};
	assign vx_c = $signed({1'b0, ccx, 12'b0}) - $signed({2'b0, px_q});
	assign vy_c = $signed({1'b0, ccy, 12'b0}) - $signed({2'b0, py_q});

	// Shared multiplier pair.
	logic signed [17:0] ma0, mb0, ma1, mb1;

	always_comb begin
		ma0 = vx_q;
		mb0 = vx_q;
		ma1 = vy_q;
		mb1 = vy_q;
		if (cmd.op == grc_pkg::OP_DOT) begin
			ma0 = 18'(ex_q);
			mb0 = vx_q;
			ma1 = 18'(ey_q);
			mb1 = vy_q;
		end else if (cmd.op == grc_pkg::OP_CRS) begin
			ma0 = 18'(ex_q);
			mb0 = vy_q;
			ma1 = 18'(ey_q);
			mb1 = vx_q;
		end
	end

	// Farthest corner; ties go to the later corner.
	logic [36:0] best;
	logic [1:0]  best_k;

	always_comb begin
		best = d2_q[0];
		best_k = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (d2_q[i] >= best) begin
				best = d2_q[i];
				best_k = 2'(i);
			end
		end
	end

	// Angular bound test.
	function automatic logic [44:0] EDGE_TAN_MUL(input logic [35:0] d);
		return {36'b0, grc_pkg::EDGE_TAN_Q16} * {9'b0, d};
	endfunction

	logic signed [36:0] cdiff;
	logic [51:0]        tan_rhs;
	logic [51:0]        tan_lhs;

	assign cdiff = 37'(prod0_q) - 37'(prod1_q);
	assign tan_rhs = 52'(EDGE_TAN_MUL(dot_q[35:0]));
	assign tan_lhs = {crs_q[35:0], 16'b0};

	// Shade of the wall for this distance.
	logic [9:0] n10;
	logic [7:0] shade_c;

	assign n10 = 10'(n_q);

	always_comb begin
		priority if ((n10 << 1) <= MD10) begin
			shade_c = grc_pkg::G_FULL;
		end else if (n10 + (n10 << 1) <= (MD10 << 1)) begin
			shade_c = grc_pkg::G_DARK;
		end else if (n10 <= MD10) begin
			shade_c = grc_pkg::G_MED;
		end else if (n10 + (n10 << 1) <= (MD10 << 2)) begin
			shade_c = grc_pkg::G_LIGHT;
		end else begin
			shade_c = grc_pkg::G_SPACE;
		end
	end

	// Glyph of row y.
	logic signed [CW-1:0] ys;
	logic [15:0]          rem;
	logic [7:0]           glyph_c;

	assign ys = $signed({1'b0, (CW-1)'(y_q)});
	assign rem = H1 - 16'(y_q);

	always_comb begin
		priority if (ys < ceil_q) begin
			glyph_c = grc_pkg::G_SPACE;
		end else if (ys > ceil_q && ys <= floor_q) begin
			glyph_c = shade_q;
		end else if ((rem << 3) < H1) begin
			glyph_c = grc_pkg::G_HASH;
		end else if ((rem << 2) < H1) begin
			glyph_c = grc_pkg::G_X;
		end else if ((rem << 3) < H3) begin
			glyph_c = grc_pkg::G_DOT;
		end else if ((rem << 4) + (rem << 2) < H9) begin
			glyph_c = grc_pkg::G_DASH;
		end else begin
			glyph_c = grc_pkg::G_SPACE;
		end
	end

	assign st.step_out = nx_out;
	assign st.step_wall = nx_wall;
	assign st.step_last = ((n_q + NW'(1)) == MAXN_V);
	assign st.k_excl = (excl_q == cmd.k);
	assign st.edge_pass = (dot_q > 37'sd0) && (tan_lhs < tan_rhs);
	assign st.out_free = !out_valid_q || out_ready;
	assign st.last_y = (y_q == YLAST);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				map_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				grc_pkg::REG_MAP_ROWS_0_TO_3:   map_q[0] <= cfg_wdata;
				grc_pkg::REG_MAP_ROWS_4_TO_7:   map_q[1] <= cfg_wdata;
				grc_pkg::REG_MAP_ROWS_8_TO_11:  map_q[2] <= cfg_wdata;
				grc_pkg::REG_MAP_ROWS_12_TO_15: map_q[3] <= cfg_wdata;
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			grc_pkg::OP_LOAD: begin
				px_q <= player_x;
				py_q <= player_y;
				ph_q <= player_angle - 12'd256 + col_off[column];
			end
			grc_pkg::OP_TRIG: begin
				ex_q <= grc_pkg::sin_q14(ph_q);
				ey_q <= grc_pkg::sin_q14(ph_q + 12'd1024);
			end
			grc_pkg::OP_INIT: begin
				tx_q <= TW'({px_q, 3'b000});
				ty_q <= TW'({py_q, 3'b000});
				n_q <= '0;
				edge_q <= 1'b0;
			end
			grc_pkg::OP_STEP: begin
				tx_q <= tx_nx;
				ty_q <= ty_nx;
				cx_q <= tcx;
				cy_q <= tcy;
				n_q <= nx_out ? MAXN_V : n_q + NW'(1);
			end
			grc_pkg::OP_VEC: begin
				vx_q <= vx_c;
				vy_q <= vy_c;
			end
			grc_pkg::OP_SQ, grc_pkg::OP_DOT: begin
				prod0_q <= ma0 * mb0;
				prod1_q <= ma1 * mb1;
			end
			grc_pkg::OP_D2: begin
				d2_q[cmd.k] <= 37'(prod0_q) + 37'(prod1_q);
			end
			grc_pkg::OP_SEL: begin
				excl_q <= best_k;
			end
			grc_pkg::OP_CRS: begin
				dot_q <= 37'(prod0_q) + 37'(prod1_q);
				prod0_q <= ma0 * mb0;
				prod1_q <= ma1 * mb1;
			end
			grc_pkg::OP_ABS: begin
				crs_q <= cdiff[36] ? 36'(-cdiff) : 36'(cdiff);
			end
			grc_pkg::OP_TAN: begin
				if (st.edge_pass) begin
					edge_q <= 1'b1;
				end
			end
			grc_pkg::OP_PREP: begin
				ceil_q <= ceil_tab[n_q];
				floor_q <= CW'(SCREEN_HEIGHT) - ceil_tab[n_q];
				shade_q <= shade_c;
				y_q <= '0;
			end
			grc_pkg::OP_EMIT: begin
				row_q <= 6'(y_q);
				glyph_q <= edge_q && (ys > ceil_q && ys <= floor_q) ? grc_pkg::G_SPACE
					: glyph_c;
				dist_q <= 6'(n_q);
				edge_out_q <= edge_q;
				last_q <= (y_q == YLAST);
				y_q <= y_q + YW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == grc_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign row = row_q;
	assign glyph = glyph_q;
	assign distance_steps = dist_q;
	assign edge_seen = edge_out_q;
	assign last_row = last_q;

endmodule

@@ rtl/grid_raycast_column_renderer_core.sv @@
// Top level of the grid raycast column renderer.
// Joins the controller (grc_ctrl) and the datapath (grc_dp); uses grc_pkg.
//
// One input word names a player position, view angle and screen column; the
// block casts that column's ray through the 16x16 wall map held in the four
// configuration registers and then returns SCREEN_HEIGHT output words, one
// per screen row, top first, with last_row marking the bottom row. A column
// is set up in the load, trig and init states, then marches one half-unit
// step per cycle, at most 2*MAX_DEPTH steps. On a wall hit it ranks the four
// tile corners by distance and checks up to 3 corners, skipping the farthest;
// each check forms the corner vector, dot and cross products, the cross
// product's magnitude and the tangent test, and the checks end at the first
// corner that lies on the ray. Ranking and checks share a single multiplier
// pair. The row data is then prepared, and the rows leave at one word per
// cycle while the consumer keeps out_ready high. A new input word is taken as
// soon as the last row word has been loaded into the output register, so the
// next column starts while that word still waits to be taken. Configuration
// is written through a plain write port with no wait state and no read-back,
// and must only be changed while the block is idle.
module grid_raycast_column_renderer_core #(
	parameter int SCREEN_WIDTH  = 120,
	parameter int SCREEN_HEIGHT = 40,
	parameter int MAX_DEPTH     = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grc_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [15:0]                    player_x,
	input  logic [15:0]                    player_y,
	input  logic [11:0]                    player_angle,
	input  logic [6:0]                     column,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [5:0]                     row,
	output logic [7:0]                     glyph,
	output logic [5:0]                     distance_steps,
	output logic                           edge_seen,
	output logic                           last_row
);

	// Commands flow from the controller to the datapath, status flows back.
	grc_pkg::cmd_t    cmd;
	grc_pkg::status_t st;

	grc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath owns the map registers and the output word register.
	grc_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.MAX_DEPTH     (MAX_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.player_x       (player_x),
		.player_y       (player_y),
		.player_angle   (player_angle),
		.column         (column),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.row            (row),
		.glyph          (glyph),
		.distance_steps (distance_steps),
		.edge_seen      (edge_seen),
		.last_row       (last_row)
	);

endmodule

@@ rtl/grc_chk.sv @@
// Port-level checker for the column renderer, bound to the top level.
// Watches the output channel and the input ready over time; no package use.
module grc_chk #(
	parameter int SCREEN_HEIGHT = 40,
	parameter int MAX_DEPTH     = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] row,
	input logic [5:0] distance_steps,
	input logic       last_row
);

	localparam logic [5:0] ROW_LAST = 6'(SCREEN_HEIGHT - 1);
	localparam logic [6:0] DMAX     = 7'(2 * MAX_DEPTH);

	// A stalled word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row) && $stable(last_row))
		else $error("output word changed while stalled");

	// The bottom row and only it carries the last-row flag.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_row == (row == ROW_LAST)))
		else $error("last_row does not match the bottom row");

	// The distance stays within the march range.
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (distance_steps != 6'd0) && ({1'b0, distance_steps} <= DMAX
			|| DMAX == 7'd64))
		else $error("distance out of range");

	// While a column still has rows to send, no new word is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_row |-> !in_ready)
		else $error("input taken in the middle of a column");

endmodule

bind grid_raycast_column_renderer_core grc_chk #(
	.SCREEN_HEIGHT (SCREEN_HEIGHT),
	.MAX_DEPTH     (MAX_DEPTH)
) u_grc_chk (.*);

@@ tb/grid_raycast_column_renderer_core_tb.sv @@
// Self-checking testbench of the grid raycast column renderer core.
// Casts column rays through random and directed wall maps and checks every row word
// against an in-bench fixed-point model; depends on grc_pkg and the core only.
`timescale 1ns / 100ps

module grid_raycast_column_renderer_core_tb;

	localparam int SW = 120;
	localparam int SH = 40;
	localparam int DEPTH = 16;
	localparam int STALL_LIMIT = 20000;

	// One row word as the block returns it.
	typedef struct packed {
		logic [5:0] row;
		logic [7:0] glyph;
		logic [5:0] steps;
		logic       edge_f;
		logic       last;
	} row_word_t;

	// Predicts the row words of each column and checks them in order.
	class column_scoreboard;
		logic [63:0] wall_map [4];
		row_word_t   pending [$];
		int          errors;

		function void clear_map();
			for (int i = 0; i < 4; i++) wall_map[i] = '0;
		endfunction

		function int qsine(input int ph);
			int q, p, r, i, f, v, a, b;
			ph &= 4095;
			q = ph >> 10;
			p = ph & 1023;
			r = (q & 1) ? 1024 - p : p;
			i = r >> 4;
			f = r & 15;
			if (i >= 64) begin
				v = grc_pkg::QSIN[64];
			end else begin
				a = grc_pkg::QSIN[i];
				b = grc_pkg::QSIN[i + 1];
				v = a + (((b - a) * f + 8) >>> 4);
			end
			return (q >= 2) ? -v : v;
		endfunction

		function bit is_wall(input int c, input int r);
			return wall_map[(r >> 2) & 3][((r & 3) * 16 + (c & 15)) & 63];
		endfunction

		function bit corner_hit(input int cx, input int cy, input int px, input int py,
				input int ex, input int ey);
			longint vx[4], vy[4], d2[4], dotp, crs;
			int ord[4], t, j;
			for (int k = 0; k < 4; k++) begin
				vx[k] = longint'((cx + (k >> 1)) << 12) - px;
				vy[k] = longint'((cy + (k & 1)) << 12) - py;
				d2[k] = vx[k] * vx[k] + vy[k] * vy[k];
				ord[k] = k;
			end
			// Stable insertion sort keeps tie order.
			for (int k = 1; k < 4; k++) begin
				t = ord[k];
				j = k - 1;
				while (j >= 0 && d2[t] < d2[ord[j]]) begin
					ord[j + 1] = ord[j];
					j--;
				end
				ord[j + 1] = t;
			end
			for (int k = 0; k < 3; k++) begin
				dotp = ex * vx[ord[k]] + ey * vy[ord[k]];
				crs = ex * vy[ord[k]] - ey * vx[ord[k]];
				if (crs < 0) crs = -crs;
				if (dotp > 0 && crs * 65536 < longint'(grc_pkg::EDGE_TAN_Q16) * dotp)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		// Notes one accepted column and queues its row words.
		function void note_column(input int px, input int py, input int ang, input int col);
			int ph, ex, ey, n, tx, ty, num, den, ceil_r, floor_r, rem;
			bit hit, edge_f;
			logic [7:0] shade, g;
			row_word_t w;
			ph = (ang + 4096 - 256 + (col * 512) / SW) & 4095;
			ex = qsine(ph);
			ey = qsine(ph + 1024);
			n = 0;
			hit = 0;
			edge_f = 0;
			while (!hit && n < 2 * DEPTH) begin
				n++;
				tx = (px << 3) + n * ex;
				ty = (py << 3) + n * ey;
				if (tx < 0 || ty < 0 || (tx >>> 15) >= grc_pkg::MAP_SIZE
						|| (ty >>> 15) >= grc_pkg::MAP_SIZE) begin
					hit = 1;
					n = 2 * DEPTH;
				end else if (is_wall(tx >>> 15, ty >>> 15)) begin
					hit = 1;
					edge_f = corner_hit(tx >>> 15, ty >>> 15, px, py, ex, ey);
				end
			end
			num = SH * n - 4 * SH;
			den = 2 * n;
			ceil_r = (num >= 0) ? num / den : -((-num) / den);
			floor_r = SH - ceil_r;
			if (2 * n <= DEPTH) shade = grc_pkg::G_FULL;
			else if (3 * n <= 2 * DEPTH) shade = grc_pkg::G_DARK;
			else if (n <= DEPTH) shade = grc_pkg::G_MED;
			else if (3 * n <= 4 * DEPTH) shade = grc_pkg::G_LIGHT;
			else shade = grc_pkg::G_SPACE;
			if (edge_f) shade = grc_pkg::G_SPACE;
			for (int y = 0; y < SH; y++) begin
				if (y < ceil_r) begin
					g = grc_pkg::G_SPACE;
				end else if (y > ceil_r && y <= floor_r) begin
					g = shade;
				end else begin
					rem = SH - y;
					if (8 * rem < SH) g = grc_pkg::G_HASH;
					else if (4 * rem < SH) g = grc_pkg::G_X;
					else if (8 * rem < 3 * SH) g = grc_pkg::G_DOT;
					else if (20 * rem < 9 * SH) g = grc_pkg::G_DASH;
					else g = grc_pkg::G_SPACE;
				end
				w.row = y[5:0];
				w.glyph = g;
				w.steps = n[5:0];
				w.edge_f = edge_f;
				w.last = (y == SH - 1);
				pending = {pending, w};
			end
		endfunction

		function void check_word(input row_word_t got);
			row_word_t want;
			if (pending.size() == 0) begin
				$error("row word with nothing expected: row %0d", got.row);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.row !== want.row) begin
				$error("row: expected %0d, got %0d", want.row, got.row); errors++;
			end
			if (got.glyph !== want.glyph) begin
				$error("glyph: expected %0d, got %0d", want.glyph, got.glyph); errors++;
			end
			if (got.steps !== want.steps) begin
				$error("distance_steps: expected %0d, got %0d", want.steps, got.steps);
				errors++;
			end
			if (got.edge_f !== want.edge_f) begin
				$error("edge_seen: expected %0d, got %0d", want.edge_f, got.edge_f); errors++;
			end
			if (got.last !== want.last) begin
				$error("last_row: expected %0d, got %0d", want.last, got.last); errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_wdata = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [15:0] player_x = '0;
	logic [15:0] player_y = '0;
	logic [11:0] player_angle = '0;
	logic [6:0]  column = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [5:0]  row;
	logic [7:0]  glyph;
	logic [5:0]  distance_steps;
	logic        edge_seen;
	logic        last_row;

	column_scoreboard board = new();
	int idle_cycles = 0;
	bit out_stall_mode = 0;

	always #1 clk = ~clk;

	grid_raycast_column_renderer_core dut (.*);

	// Output side: sample on the rising edge, every accepted word is checked.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_word({row, glyph, distance_steps, edge_seen, last_row});
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver stalls on its own pattern: runs of free flow alternate with
	// stretches where ready toggles at random.
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0) out_stall_mode = ~out_stall_mode;
			out_ready <= out_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		board.wall_map[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_map(input logic [63:0] w0, w1, w2, w3);
		write_reg(grc_pkg::REG_MAP_ROWS_0_TO_3, w0);
		write_reg(grc_pkg::REG_MAP_ROWS_4_TO_7, w1);
		write_reg(grc_pkg::REG_MAP_ROWS_8_TO_11, w2);
		write_reg(grc_pkg::REG_MAP_ROWS_12_TO_15, w3);
	endtask

	// Presents one word and holds it until accepted; the model is told at that edge.
	task automatic send_column(input logic [15:0] px, py, input logic [11:0] ang,
			input logic [6:0] col);
		in_valid <= 1'b1;
		player_x <= px;
		player_y <= py;
		player_angle <= ang;
		column <= col;
		do @(posedge clk); while (!in_ready);
		board.note_column(int'(px), int'(py), int'(ang), int'(col));
		@(negedge clk);
	endtask

	// Sender bursts: after a burst valid drops for a random gap.
	task automatic maybe_gap();
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 120)) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (board.pending.size() == 0);
		repeat (200) @(negedge clk);
	endtask

	task automatic random_column();
		logic [15:0] px, py;
		case ($urandom_range(0, 4))
			0: begin px = 16'($urandom); py = 16'($urandom); end
			// Mostly inside the map away from its rim.
			default: begin
				px = 16'($urandom_range(16'h1000, 16'hEFFF));
				py = 16'($urandom_range(16'h1000, 16'hEFFF));
			end
		endcase
		// Players sitting exactly on a tile corner now and then.
		if ($urandom_range(0, 9) == 0) begin
			px[11:0] = '0;
			py[11:0] = '0;
		end
		send_column(px, py, 12'($urandom),
			7'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, SW - 1)));
	endtask

	// Random wall word, each bit set with the given percent chance.
	function automatic logic [63:0] rand_word(input int fill);
		logic [63:0] w;
		w = '0;
		for (int b = 0; b < 64; b++) w[b] = ($urandom_range(0, 99) < fill);
		return w;
	endfunction

	initial begin
		board.clear_map();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty map, so every ray leaves the map or runs to full depth.
		send_column(16'h0000, 16'h0000, 12'h000, 7'd0);
		send_column(16'hFFFF, 16'hFFFF, 12'hFFF, 7'd119);
		send_column(16'h8000, 16'h8000, 12'h400, 7'd127);
		drain();

		// Walls everywhere: the first step hits, nearest distance and corner checks.
		load_map('1, '1, '1, '1);
		send_column(16'h8000, 16'h8000, 12'h000, 7'd60);
		send_column(16'h8000, 16'h8000, 12'h200, 7'd60);   // ray through a corner
		send_column(16'h7800, 16'h7800, 12'h200, 7'd60);
		send_column(16'h8800, 16'h8800, 12'h800, 7'd0);
		send_column(16'h5555, 16'hAAAA, 12'hAAA, 7'd85);
		drain();

		// Framed room: walls on the border rows and columns only.
		load_map(64'h8001_8001_8001_FFFF, 64'h8001_8001_8001_8001,
			64'h8001_8001_8001_8001, 64'hFFFF_8001_8001_8001);
		for (int a = 0; a < 4096; a += 512) send_column(16'h1800, 16'h1800, 12'(a), 7'd60);
		send_column(16'h8000, 16'h8000, 12'h100, 7'd42);
		send_column(16'hE800, 16'hE800, 12'hC00, 7'd7);
		drain();

		// Random maps with random columns, sparse to dense.
		for (int phase = 0; phase < 6; phase++) begin
			load_map(rand_word(phase * 8), rand_word(phase * 8),
				rand_word(phase * 8), rand_word(phase * 8));
			for (int k = 0; k < 19; k++) begin
				random_column();
				maybe_gap();
			end
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
